[design/xsr_pkg.sv]
// Package: shared types, constants and reset values of the xoshiro256+ generator.
`default_nettype none
package xsr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned NumWords = 4;
  localparam int unsigned IdxW = $clog2(NumWords);

  localparam logic [WordW-1:0] SeedReset = 64'd12345;
  localparam logic [WordW-1:0] MixGolden = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMul2 = 64'h94d049bb133111eb;
  localparam int unsigned MixShift1 = 30;
  localparam int unsigned MixShift2 = 27;
  localparam int unsigned MixShift3 = 31;
  localparam int unsigned XorShl = 17;
  localparam int unsigned RotAmt = 45;
  localparam int unsigned Frac53Shift = 11;
  localparam int unsigned MidShift = 16;
  localparam int unsigned TopShift = 40;
  localparam logic [WordW-1:0] Field24Mask = 64'hffffff;

  // Output format codes
  localparam logic [1:0] FmtRaw = 2'd0;
  localparam logic [1:0] FmtFrac53 = 2'd1;
  localparam logic [1:0] FmtMid24 = 2'd2;
  localparam logic [1:0] FmtTop24 = 2'd3;

  // Opcodes
  localparam logic OpDraw = 1'b0;
  localparam logic OpReseed = 1'b1;

  // Multiplier constant select
  localparam logic PhaseMul1 = 1'b0;
  localparam logic PhaseMul2 = 1'b1;

  // Result entry: done flag above the value
  localparam int unsigned ResW = WordW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MLL,
    ST_MHL,
    ST_MLH,
    ST_XS,
    ST_FIN
  } xsr_state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DRAW,
    CMD_ADD,
    CMD_MLL,
    CMD_MHL,
    CMD_MLH,
    CMD_XS,
    CMD_FIN
  } xsr_cmd_e;

  typedef struct packed {
    xsr_cmd_e        op;
    logic            phase;
    logic [IdxW-1:0] word_idx;
  } xsr_cmd_t;

  // Splitmix64 mix, used only to work out the reset state at elaboration
  function automatic logic [WordW-1:0] splitmix_mix(input logic [WordW-1:0] v);
    logic [WordW-1:0] z;
    z = v + MixGolden;
    z = (z ^ (z >> MixShift1)) * MixMul1;
    z = (z ^ (z >> MixShift2)) * MixMul2;
    return z ^ (z >> MixShift3);
  endfunction

  localparam logic [WordW-1:0] ResetW0 = splitmix_mix(SeedReset);
  localparam logic [WordW-1:0] ResetW1 = splitmix_mix(ResetW0);
  localparam logic [WordW-1:0] ResetW2 = splitmix_mix(ResetW1);
  localparam logic [WordW-1:0] ResetW3 = splitmix_mix(ResetW2);

endpackage
`default_nettype wire

[design/xsr_out_fifo.sv]
// Two-entry result queue between the datapath and the master stream side.
`default_nettype none
module xsr_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [xsr_pkg::ResW-1:0] push_data_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [xsr_pkg::ResW-1:0] out_data_o
);
  import xsr_pkg::*;

  logic [1:0][ResW-1:0] mem_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign room_o      = (count_q != 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[design/xsr_ctrl.sv]
// Controller: accepts transactions and sequences the splitmix64 reseed.
`default_nettype none
module xsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  input  logic              room_i,
  output logic              in_ready_o,
  output logic              push_o,
  output xsr_pkg::xsr_cmd_t cmd_o
);
  import xsr_pkg::*;

  xsr_state_e      state_q, state_d;
  logic            phase_q, phase_d;
  logic [IdxW-1:0] word_q, word_d;
  logic            accept;
  logic            last_word;

  assign in_ready_o = (state_q == ST_IDLE) && room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last_word  = (word_q == IdxW'(NumWords - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_opcode_i == OpReseed)) state_d = ST_ADD;
      end
      ST_ADD:  state_d = ST_MLL;
      ST_MLL:  state_d = ST_MHL;
      ST_MHL:  state_d = ST_MLH;
      ST_MLH:  state_d = (phase_q == PhaseMul1) ? ST_XS : ST_FIN;
      ST_XS:   state_d = ST_MLL;
      ST_FIN:  state_d = last_word ? ST_IDLE : ST_ADD;
      default: state_d = ST_IDLE;
    endcase
  end

  // Word index and multiplier constant select
  always_comb begin
    phase_d = phase_q;
    word_d  = word_q;
    unique case (state_q)
      ST_IDLE: if (accept) word_d = '0;
      ST_ADD:  phase_d = PhaseMul1;
      ST_XS:   phase_d = PhaseMul2;
      ST_FIN:  word_d = word_q + IdxW'(1);
      default: ;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.phase    = phase_q;
    cmd_o.word_idx = word_q;
    cmd_o.op       = CMD_NONE;
    push_o         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_opcode_i == OpDraw)) begin
          cmd_o.op = CMD_DRAW;
          push_o   = 1'b1;
        end
      end
      ST_ADD:  cmd_o.op = CMD_ADD;
      ST_MLL:  cmd_o.op = CMD_MLL;
      ST_MHL:  cmd_o.op = CMD_MHL;
      ST_MLH:  cmd_o.op = CMD_MLH;
      ST_XS:   cmd_o.op = CMD_XS;
      ST_FIN: begin
        cmd_o.op = CMD_FIN;
        push_o   = last_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PhaseMul1;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      word_q  <= word_d;
    end
  end

  a_reseed_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_opcode_i == OpReseed)) |=> (state_q == ST_ADD) && (word_q == '0))
    else $error("reseed did not start at word zero");

  a_ack_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && last_word) |-> push_o)
    else $error("reseed finished without acknowledgement");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (room_i || (state_q == ST_FIN)))
    else $error("draw pushed into a full queue");

  a_second_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_XS) |=> (state_q == ST_MLL) && (phase_q == PhaseMul2))
    else $error("second multiply not selected after xorshift");

endmodule
`default_nettype wire

[design/xsr_datapath.sv]
// Datapath: generator words, seed register, shared 32x32 multiplier, result formatting.
`default_nettype none
module xsr_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [xsr_pkg::WordW-1:0] cfg_wdata_i,
  input  logic [1:0]                fmt_i,
  input  xsr_pkg::xsr_cmd_t         cmd_i,
  output logic [xsr_pkg::ResW-1:0]  push_data_o
);
  import xsr_pkg::*;

  logic [NumWords-1:0][WordW-1:0] words_q, words_d;
  logic [WordW-1:0] seed_q;
  logic [WordW-1:0] prev_q, prev_d;
  logic [WordW-1:0] z_q, z_d;
  logic [WordW-1:0] acc_q, acc_d;

  logic [WordW-1:0] add_t, mix_const, mix_out;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] tsh, n0, n1, n2, n3, r3, sum, fmt_val;

  // Shared multiplier: one 32x32 partial product per cycle
  always_comb begin
    mix_const = (cmd_i.phase == PhaseMul2) ? MixMul2 : MixMul1;
    mul_a = (cmd_i.op == CMD_MHL) ? z_q[WordW-1:HalfW] : z_q[HalfW-1:0];
    mul_b = (cmd_i.op == CMD_MLH) ? mix_const[WordW-1:HalfW] : mix_const[HalfW-1:0];
    prod  = WordW'(mul_a) * WordW'(mul_b);
  end

  assign add_t   = ((cmd_i.word_idx == '0) ? seed_q : prev_q) + MixGolden;
  assign mix_out = acc_q ^ (acc_q >> MixShift3);

  // One xoshiro256+ step and the sum of the new words 0 and 3
  always_comb begin
    tsh = words_q[1] << XorShl;
    n2  = words_q[2] ^ words_q[0];
    n3  = words_q[3] ^ words_q[1];
    n1  = words_q[1] ^ n2;
    n0  = words_q[0] ^ n3;
    r3  = (n3 << RotAmt) | (n3 >> (WordW - RotAmt));
    sum = n0 + r3;
    unique case (fmt_i)
      FmtRaw:    fmt_val = sum;
      FmtFrac53: fmt_val = sum >> Frac53Shift;
      FmtMid24:  fmt_val = (sum >> MidShift) & Field24Mask;
      FmtTop24:  fmt_val = sum >> TopShift;
      default:   fmt_val = sum;
    endcase
  end

  // Sequence commands
  always_comb begin
    words_d = words_q;
    prev_d  = prev_q;
    z_d     = z_q;
    acc_d   = acc_q;
    push_data_o = {1'b0, fmt_val};
    unique case (cmd_i.op)
      CMD_NONE: ;
      CMD_DRAW: begin
        words_d[0] = n0;
        words_d[1] = n1;
        words_d[2] = n2 ^ tsh;
        words_d[3] = r3;
      end
      CMD_ADD: z_d = add_t ^ (add_t >> MixShift1);
      CMD_MLL: acc_d = prod;
      CMD_MHL, CMD_MLH: acc_d = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
      CMD_XS:  z_d = acc_q ^ (acc_q >> MixShift2);
      CMD_FIN: begin
        words_d[cmd_i.word_idx] = mix_out;
        prev_d = mix_out;
        push_data_o = {1'b1, {WordW{1'b0}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q[0] <= ResetW0;
      words_q[1] <= ResetW1;
      words_q[2] <= ResetW2;
      words_q[3] <= ResetW3;
      seed_q     <= SeedReset;
    end else begin
      words_q <= words_d;
      if (cfg_we_i) seed_q <= cfg_wdata_i;
    end
  end

  // Hold mixing scratch values
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    z_q    <= z_d;
    acc_q  <= acc_d;
  end

endmodule
`default_nettype wire

[design/xoshiro256plus_generator_top.sv]
// Top level: xoshiro256+ generator with splitmix64 reseeding on stream ports.
//
// channel  | direction | handshake                 | payload
// s_axis   | in        | s_axis_tvalid/tready      | tdata[1:0] output_format, tuser[0] opcode
// m_axis   | out       | m_axis_tvalid/tready      | tdata[63:0] random_value, tuser[0] reseed_done
// cfg      | in        | cfg_we_i (no wait)        | cfg_wdata_i[63:0] seed_value
//
// A draw's result is pushed into the output queue on accept and is there the cycle after.
// A reseed is the accept cycle and four splitmix64 mixes, each through states ADD,
// MLL, MHL, MLH, XS, MLL, MHL, MLH, FIN on the shared 32x32 multiplier (three
// partial products per 64-bit multiply). Reset loads the expansion of seed 12345 at once.
// Results wait in a two-entry queue; input is held off while it is full.
`default_nettype none
module xoshiro256plus_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] output_format, [7:2] zero
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] random_value
  output logic [0:0]  m_axis_tuser    // [0] reseed_done
);
  import xsr_pkg::*;

  xsr_cmd_t        cmd;
  logic            push;
  logic            room;
  logic [ResW-1:0] push_data;
  logic [ResW-1:0] out_data;

  xsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser[0]),
    .room_i      (room),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  xsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fmt_i       (s_axis_tdata[1:0]),
    .cmd_i       (cmd),
    .push_data_o (push_data)
  );

  xsr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = out_data[WordW-1:0];
  assign m_axis_tuser = out_data[ResW-1 -: 1];

endmodule
`default_nettype wire
